/* src/bcpd_pkg.sv */
// ----------------------------------------------------------------------------
// bcpd_pkg
// Types and constants shared by the button click / press detector.
// ----------------------------------------------------------------------------
package bcpd_pkg;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_CLICK    = 3'd1;
  localparam logic [2:0] EV_DOUBLE   = 3'd2;
  localparam logic [2:0] EV_MULTI    = 3'd3;
  localparam logic [2:0] EV_PRESS    = 3'd4;
  localparam logic [2:0] EV_LONG     = 3'd5;
  localparam logic [2:0] EV_LONG_REL = 3'd6;

  localparam logic [2:0] CFG_ENABLE        = 3'd0;
  localparam logic [2:0] CFG_ACTIVE_LEVEL  = 3'd1;
  localparam logic [2:0] CFG_DEBOUNCE_MS   = 3'd2;
  localparam logic [2:0] CFG_END_GAP_MS    = 3'd3;
  localparam logic [2:0] CFG_PRESS_MS      = 3'd4;
  localparam logic [2:0] CFG_LONG_PRESS_MS = 3'd5;

  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [15:0] END_GAP_MS_RST    = 16'd600;
  localparam logic [15:0] PRESS_MS_RST      = 16'd1000;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd5000;

  typedef struct packed {
    logic        level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        cur_level;
    logic [15:0] click_count;
    logic [31:0] active_ms;
    logic [31:0] inactive_ms;
  } out_t;

  typedef struct packed {
    logic        enable;
    logic        active_level;
    logic [15:0] debounce_ms;
    logic [15:0] end_gap_ms;
    logic [15:0] press_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic        raw_prev_level;
    logic [31:0] stable_start_ms;
    logic        qualified_level;
    logic [15:0] running_clicks;
    logic [15:0] latched_clicks;
    logic [2:0]  pending_event;
    logic [31:0] last_active_ms;
    logic [31:0] last_inactive_ms;
  } state_t;

endpackage

/* src/button_click_press_detector.sv */
// An accepted sample is held in the input register, and its result is registered at out_data.
// Throughput: one sample per cycle unless out_stall holds the result; the detector state updates in the
// single compute stage between the input register and the result register.
// Reset (rst, synchronous, active high) clears both pipeline stages, loads the
// configuration defaults and returns the detector state to released/idle.
// ----------------------------------------------------------------------------
// button_click_press_detector
// Debounced button sampler that reports clicks, double / multi clicks,
// press, long press and long-press release.
// ----------------------------------------------------------------------------
module button_click_press_detector (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bcpd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bcpd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import bcpd_pkg::*;

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  out_t   res;
  in_t    in_q;
  logic   in_valid_q;
  logic   advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_q && (!out_valid || !out_stall);
  assign in_stall  = in_valid_q && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b0;
      cfg.active_level  <= 1'b0;
      cfg.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg.end_gap_ms    <= END_GAP_MS_RST;
      cfg.press_ms      <= PRESS_MS_RST;
      cfg.long_press_ms <= LONG_PRESS_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:        cfg.enable        <= cfg_data[0];
        CFG_ACTIVE_LEVEL:  cfg.active_level  <= cfg_data[0];
        CFG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_data;
        CFG_END_GAP_MS:    cfg.end_gap_ms    <= cfg_data;
        CFG_PRESS_MS:      cfg.press_ms      <= cfg_data;
        CFG_LONG_PRESS_MS: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  bcpd_step u_step (
    .cfg     (cfg),
    .st      (st),
    .smp     (in_q),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.raw_prev_level   <= 1'b1;
      st.stable_start_ms  <= 32'd0;
      st.qualified_level  <= 1'b1;
      st.running_clicks   <= 16'd0;
      st.latched_clicks   <= 16'd0;
      st.pending_event    <= EV_NONE;
      st.last_active_ms   <= 32'd0;
      st.last_inactive_ms <= 32'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_disabled_no_event: assert property (@(posedge clk) disable iff (rst)
    advance && !cfg.enable |=> out_data.event_res == EV_NONE)
    else $error("event reported while disabled");

  a_event_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.event_res != 3'd7)
    else $error("undefined event code");

  a_cur_level_tracks: assert property (@(posedge clk) disable iff (rst)
    advance && cfg.enable |=> out_data.cur_level == $past(in_q.level))
    else $error("cur_level does not follow sampled level");

  a_held_input: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("pending sample lost while stalled");

  a_long_once: assert property (@(posedge clk) disable iff (rst)
    advance && st.pending_event == EV_LONG |=> out_data.event_res != EV_LONG)
    else $error("long press reported twice");
`endif

endmodule

/* src/bcpd_step.sv */
// ----------------------------------------------------------------------------
// bcpd_step
// Next-state and result logic for one sample: debounce timing, click
// counting and press / long-press classification.
// ----------------------------------------------------------------------------
module bcpd_step (
  input  bcpd_pkg::cfg_t   cfg,
  input  bcpd_pkg::state_t st,
  input  bcpd_pkg::in_t    smp,
  output bcpd_pkg::state_t st_next,
  output bcpd_pkg::out_t   res
);
  import bcpd_pkg::*;

  logic [31:0] held;
  logic [31:0] start_ms;
  logic [15:0] clicks_inc;
  logic [2:0]  ev;
  logic        over_debounce;

  always_comb begin
    st_next       = st;
    ev            = EV_NONE;
    start_ms      = (smp.level != st.raw_prev_level) ? smp.now_ms : st.stable_start_ms;
    held          = smp.now_ms - start_ms;
    over_debounce = held > {16'd0, cfg.debounce_ms};
    clicks_inc    = st.running_clicks + 16'd1;

    if (cfg.enable) begin
      st_next.raw_prev_level  = smp.level;
      st_next.stable_start_ms = start_ms;
      if (smp.level == cfg.active_level) begin
        if (over_debounce) begin
          st_next.last_active_ms = held;
          if (st.qualified_level != smp.level) begin
            st_next.qualified_level = smp.level;
            st_next.running_clicks  = clicks_inc;
            if (clicks_inc == 16'd0) begin
              st_next.pending_event = EV_NONE;
            end else if (clicks_inc == 16'd1) begin
              st_next.pending_event = EV_CLICK;
            end else if (clicks_inc == 16'd2) begin
              st_next.pending_event = EV_DOUBLE;
            end else begin
              st_next.pending_event = EV_MULTI;
            end
          end else if (st.running_clicks <= 16'd1) begin
            if (held > {16'd0, cfg.press_ms} && held < {16'd0, cfg.long_press_ms}) begin
              st_next.pending_event = EV_PRESS;
            end else if (held > {16'd0, cfg.long_press_ms} && st.pending_event != EV_LONG) begin
              st_next.pending_event = EV_LONG;
              ev                    = EV_LONG;
            end
          end
        end
      end else if (over_debounce) begin
        st_next.qualified_level  = smp.level;
        st_next.last_inactive_ms = held;
        if (held > {16'd0, cfg.end_gap_ms}) begin
          st_next.latched_clicks = st.running_clicks;
          st_next.running_clicks = 16'd0;
          st_next.pending_event  = EV_NONE;
          if (st.pending_event == EV_LONG) begin
            ev = EV_LONG_REL;
          end else if (st.pending_event inside {[EV_CLICK:EV_PRESS]}) begin
            ev = st.pending_event;
          end
        end
      end
    end

    res.event_res   = ev;
    res.cur_level   = st_next.raw_prev_level;
    res.click_count = st_next.latched_clicks;
    res.active_ms   = st_next.last_active_ms;
    res.inactive_ms = st_next.last_inactive_ms;
  end

endmodule
